### src/cns_pkg.sv
// ----------------------------------------------------------------------------
// cns_pkg
// Shared types and codes for the cutoff neighbor search unit.
// ----------------------------------------------------------------------------
package cns_pkg;

	// input item actions
	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_WRITE  = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;
	localparam logic [1:0] ACT_IGNORE = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_ALLOW_SAME = 2'd0;
	localparam logic [1:0] REG_INCL_PAIRS = 2'd1;
	localparam logic [1:0] REG_MIN_CUT    = 2'd2;
	localparam logic [1:0] REG_MAX_CUT    = 2'd3;

	localparam logic [30:0] MAX_CUT_RESET = 31'd1000;

	// one table entry, coordinates already sign extended
	typedef struct packed {
		logic        valid;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [15:0] strand;
		logic        has_partner;
		logic [5:0]  partner;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

endpackage

### src/cns_cell.sv
// ----------------------------------------------------------------------------
// cns_cell
// One table slot of the entry ring; shifts its entry to the neighbor on scan.
// ----------------------------------------------------------------------------
module cns_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            clr,
	input  logic            wr,
	input  cns_pkg::entry_t wdata,
	input  logic            shift,
	input  cns_pkg::entry_t shift_in,
	output cns_pkg::entry_t entry
);
	import cns_pkg::*;

	logic   valid_q;
	entry_t data_q;

	// valid bit, cleared by reset and clear items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clr) begin
			valid_q <= 1'b0;
		end else if (wr) begin
			valid_q <= wdata.valid;
		end else if (shift) begin
			valid_q <= shift_in.valid;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (wr) begin
			data_q <= wdata;
		end else if (shift) begin
			data_q <= shift_in;
		end
	end

	// payload with the valid bit taken from the reset flop
	always_comb begin
		entry       = data_q;
		entry.valid = valid_q;
	end

endmodule

### src/cns_dist.sv
// ----------------------------------------------------------------------------
// cns_dist
// Three stage squared distance pipeline with cutoff window compare.
// ----------------------------------------------------------------------------
module cns_dist #(
	parameter int IW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          in_vld,
	input  logic [IW-1:0] in_idx,
	input  logic [31:0]   ax,
	input  logic [31:0]   ay,
	input  logic [31:0]   az,
	input  logic [31:0]   bx,
	input  logic [31:0]   by,
	input  logic [31:0]   bz,
	input  logic [61:0]   lo,
	input  logic [61:0]   hi,
	output logic          hit,
	output logic [IW-1:0] hit_idx,
	output logic          busy
);
	import cns_pkg::*;

	logic signed [32:0] dx, dy, dz;
	logic [32:0]        mx, my, mz;
	logic               big;
	logic               vld_s1, vld_s2, vld_s3;
	logic               big_s1, big_s2;
	logic [IW-1:0]      idx_s1, idx_s2, idx_s3;
	logic [30:0]        mx_s1, my_s1, mz_s1;
	logic [61:0]        sx_s2, sy_s2, sz_s2;
	logic [63:0]        sum;
	logic               hit_s3;

	// signed differences and magnitudes
	always_comb begin
		dx  = $signed({ax[31], ax}) - $signed({bx[31], bx});
		dy  = $signed({ay[31], ay}) - $signed({by[31], by});
		dz  = $signed({az[31], az}) - $signed({bz[31], bz});
		mx  = dx[32] ? 33'(-dx) : 33'(dx);
		my  = dy[32] ? 33'(-dy) : 33'(dy);
		mz  = dz[32] ? 33'(-dz) : 33'(dz);
		big = mx[32] | mx[31] | my[32] | my[31] | mz[32] | mz[31];
	end

	assign sum = {2'b00, sx_s2} + {2'b00, sy_s2} + {2'b00, sz_s2};

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// stage data
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1 <= in_idx;
			big_s1 <= big;
			mx_s1  <= mx[30:0];
			my_s1  <= my[30:0];
			mz_s1  <= mz[30:0];
			idx_s2 <= idx_s1;
			big_s2 <= big_s1;
			sx_s2  <= 62'(mx_s1) * 62'(mx_s1);
			sy_s2  <= 62'(my_s1) * 62'(my_s1);
			sz_s2  <= 62'(mz_s1) * 62'(mz_s1);
			idx_s3 <= idx_s2;
			hit_s3 <= !big_s2 && (sum > {2'b00, lo}) && (sum < {2'b00, hi});
		end
	end

	assign hit     = vld_s3 && hit_s3;
	assign hit_idx = idx_s3;
	assign busy    = vld_s1 | vld_s2 | vld_s3;

endmodule

### src/cutoff_neighbor_search_unit.sv
// ----------------------------------------------------------------------------
// cutoff_neighbor_search_unit
// Entry table held as a ring of cells; a query rotates the ring past one
// distance pipeline and reports entries inside the cutoff window.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | action index present pos_* strand_id ...
//  out     | output    | out_valid/out_ready | neighbor_index found last
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index cfg_data
//
//  clear and write items are taken in idle and leave the unit idle
//  a query of a present entry steps through load, one ring rotation, a drain of
//  the three stage distance pipeline until it is empty, and finish; a query
//  of an absent entry goes straight to finish
//  output stalls freeze the ring and the pipeline in place
//  reset empties the table at once; entry payload is undefined until written
// ----------------------------------------------------------------------------
module cutoff_neighbor_search_unit #(
	parameter int MAX_ENTRIES = 64,
	parameter int COORD_BITS  = 32,
	parameter int STRAND_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [5:0]  index,
	input  logic        present,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] pos_z,
	input  logic [15:0] strand_id,
	input  logic        has_pair,
	input  logic [5:0]  pair_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  neighbor_index,
	output logic        found,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data
);
	import cns_pkg::*;

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam logic [IW-1:0] LAST_J = IW'(MAX_ENTRIES - 1);
	localparam logic [31:0] STRAND_MASK = (32'd1 << STRAND_BITS) - 32'd1;

	state_t state_q, state_d;

	logic        allow_same_q, incl_pairs_q;
	logic [30:0] min_cut_q, max_cut_q;
	logic [61:0] lo_q, hi_q;

	entry_t cells [MAX_ENTRIES];
	entry_t wentry, head, qent_q;
	logic [5:0]    qidx_q;
	logic [IW-1:0] j_q;
	logic          adv, in_acc, scan_en, q_ok;
	logic          cand, hit, busy;
	logic [IW-1:0] hit_idx;
	logic          pend_v_q;
	logic [IW-1:0] pend_q;
	logic          out_valid_q, found_q, last_q;
	logic [5:0]    nidx_q;

	assign adv       = !out_valid_q || out_ready;
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_same_q <= 1'b0;
			incl_pairs_q <= 1'b0;
			min_cut_q    <= '0;
			max_cut_q    <= MAX_CUT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ALLOW_SAME: allow_same_q <= cfg_data[0];
				REG_INCL_PAIRS: incl_pairs_q <= cfg_data[0];
				REG_MIN_CUT:    min_cut_q    <= cfg_data;
				REG_MAX_CUT:    max_cut_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// write data, coordinates sign extended from COORD_BITS
	always_comb begin
		wentry.valid       = present;
		wentry.x           = 32'($signed(pos_x << (32 - COORD_BITS)) >>> (32 - COORD_BITS));
		wentry.y           = 32'($signed(pos_y << (32 - COORD_BITS)) >>> (32 - COORD_BITS));
		wentry.z           = 32'($signed(pos_z << (32 - COORD_BITS)) >>> (32 - COORD_BITS));
		wentry.strand      = 16'({16'd0, strand_id} & STRAND_MASK);
		wentry.has_partner = has_pair;
		wentry.partner     = pair_index;
	end

	// ring of entry cells
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		cns_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.clr      (in_acc && action == ACT_CLEAR),
			.wr       (in_acc && action == ACT_WRITE && index == 6'(i)),
			.wdata    (wentry),
			.shift    (scan_en && adv),
			.shift_in (cells[(i + 1) % MAX_ENTRIES]),
			.entry    (cells[i])
		);
	end

	assign head = cells[0];
	assign q_ok = (32'(index) < MAX_ENTRIES) && cells[index[IW-1:0]].valid;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_acc && action == ACT_QUERY) state_d = q_ok ? ST_LOAD : ST_FINISH;
			ST_LOAD:   state_d = ST_SCAN;
			ST_SCAN:   if (adv && j_q == LAST_J) state_d = ST_DRAIN;
			ST_DRAIN:  if (!busy) state_d = ST_FINISH;
			ST_FINISH: if (adv) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		scan_en  = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_SCAN: scan_en  = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// query capture, squared cutoffs and scan counter
	always_ff @(posedge clk) begin
		if (in_acc) begin
			qent_q <= cells[index[IW-1:0]];
			qidx_q <= index;
			j_q    <= '0;
		end
		if (state_q == ST_LOAD) begin
			lo_q <= 62'(min_cut_q) * 62'(min_cut_q);
			hi_q <= 62'(max_cut_q) * 62'(max_cut_q);
		end
		if (scan_en && adv) j_q <= j_q + 1'b1;
	end

	// candidate filter at the head of the ring
	assign cand = scan_en && head.valid && (6'(j_q) != qidx_q)
		&& (allow_same_q || head.strand != qent_q.strand)
		&& (incl_pairs_q || !head.has_partner || head.partner != qidx_q);

	cns_dist #(.IW(IW)) u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (cand),
		.in_idx  (j_q),
		.ax      (qent_q.x),
		.ay      (qent_q.y),
		.az      (qent_q.z),
		.bx      (head.x),
		.by      (head.y),
		.bz      (head.z),
		.lo      (lo_q),
		.hi      (hi_q),
		.hit     (hit),
		.hit_idx (hit_idx),
		.busy    (busy)
	);

	// one hit held back so the final one can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_v_q    <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b0;
			if (hit) begin
				out_valid_q <= pend_v_q;
				pend_v_q    <= 1'b1;
			end
			if (state_q == ST_FINISH) begin
				out_valid_q <= 1'b1;
				pend_v_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (hit) begin
				nidx_q  <= 6'(pend_q);
				found_q <= 1'b1;
				last_q  <= 1'b0;
				pend_q  <= hit_idx;
			end
			if (state_q == ST_FINISH) begin
				nidx_q  <= pend_v_q ? 6'(pend_q) : 6'd0;
				found_q <= pend_v_q;
				last_q  <= 1'b1;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign neighbor_index = nidx_q;
	assign found          = found_q;
	assign last           = last_q;

	// checks
	a_notfound_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> last)
		else $error("not-found result without last");
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !busy && !pend_v_q)
		else $error("work left over in idle");
	a_finish_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH && adv |=> out_valid && last)
		else $error("query ended without final result");

endmodule

### tb/tb_cutoff_neighbor_search_unit.sv
// ----------------------------------------------------------------------------
// tb_cutoff_neighbor_search_unit
// Drives clear, write and query items into the neighbor search unit under
// several cutoff and filter settings, predicts every neighbor list from a
// private copy of the table and checks each result item in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class neighbor_board;
	// private copy of the table and registers
	bit          tab_valid [64];
	logic [63:0] tab_x [64];
	logic [63:0] tab_y [64];
	logic [63:0] tab_z [64];
	bit   [15:0] tab_strand [64];
	bit          tab_has_partner [64];
	bit   [5:0]  tab_partner [64];
	bit          same_ok;
	bit          pairs_ok;
	bit   [30:0] lo_cut;
	bit   [30:0] hi_cut;
	bit   [7:0]  hits_q [$];
	int          errors;

	function new();
		for (int i = 0; i < 64; i++) tab_valid[i] = 0;
		same_ok = 0;
		pairs_ok = 0;
		lo_cut = 0;
		hi_cut = 31'd1000;
		errors = 0;
	endfunction

	function void set_reg(bit [1:0] idx, bit [30:0] val);
		case (idx)
			cns_pkg::REG_ALLOW_SAME: same_ok = val[0];
			cns_pkg::REG_INCL_PAIRS: pairs_ok = val[0];
			cns_pkg::REG_MIN_CUT: lo_cut = val;
			default: hi_cut = val;
		endcase
	endfunction

	function logic [63:0] mag(logic [63:0] a, logic [63:0] b);
		logic [63:0] d;
		d = a - b;
		if (d[63]) d = -d;
		return d;
	endfunction

	// note an accepted input item and queue the results it causes
	function void note_item(bit [1:0] act, bit [5:0] idx, bit pres, bit [31:0] px,
			bit [31:0] py, bit [31:0] pz, bit [15:0] sid, bit hp, bit [5:0] pi);
		logic [63:0] dx, dy, dz, d2, lo, hi;
		bit   [7:0]  ent;
		int n;
		n = 0;
		if (act == cns_pkg::ACT_CLEAR) begin
			for (int i = 0; i < 64; i++) tab_valid[i] = 0;
		end else if (act == cns_pkg::ACT_WRITE) begin
			tab_valid[idx] = pres;
			tab_x[idx] = {{32{px[31]}}, px};
			tab_y[idx] = {{32{py[31]}}, py};
			tab_z[idx] = {{32{pz[31]}}, pz};
			tab_strand[idx] = sid;
			tab_has_partner[idx] = hp;
			tab_partner[idx] = pi;
		end else if (act == cns_pkg::ACT_QUERY) begin
			if (tab_valid[idx]) begin
				lo = 64'(lo_cut) * 64'(lo_cut);
				hi = 64'(hi_cut) * 64'(hi_cut);
				for (int j = 0; j < 64; j++) begin
					if (j == idx || !tab_valid[j]) continue;
					if (!same_ok && tab_strand[j] == tab_strand[idx]) continue;
					if (!pairs_ok && tab_has_partner[j] && tab_partner[j] == idx) continue;
					dx = mag(tab_x[idx], tab_x[j]);
					dy = mag(tab_y[idx], tab_y[j]);
					dz = mag(tab_z[idx], tab_z[j]);
					if (dx >= 64'h8000_0000 || dy >= 64'h8000_0000 || dz >= 64'h8000_0000)
						continue;
					d2 = dx * dx + dy * dy + dz * dz;
					if (d2 > lo && d2 < hi) begin
						ent = {j[5:0], 1'b1, 1'b0};
						hits_q.insert(hits_q.size(), ent);
						n++;
					end
				end
			end
			if (n == 0) begin
				ent = {6'd0, 1'b0, 1'b1};
				hits_q.insert(hits_q.size(), ent);
			end else hits_q[$][0] = 1'b1;
		end
	endfunction

	// compare one result item with the oldest expectation
	function void check_result(bit [5:0] ni, bit fnd, bit lst);
		bit [7:0] e;
		if (hits_q.size() == 0) begin
			$display("%0t: unexpected result idx=%0d found=%0b last=%0b", $time, ni, fnd, lst);
			errors++;
			return;
		end
		e = hits_q.pop_front();
		if (e[7:2] != ni) begin
			$display("%0t: neighbor_index expected %0d actual %0d", $time, e[7:2], ni);
			errors++;
		end
		if (e[1] != fnd) begin
			$display("%0t: found expected %0b actual %0b", $time, e[1], fnd);
			errors++;
		end
		if (e[0] != lst) begin
			$display("%0t: last expected %0b actual %0b", $time, e[0], lst);
			errors++;
		end
	endfunction
endclass

module tb_cutoff_neighbor_search_unit;
	import cns_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [1:0]  action = 0;
	logic [5:0]  index = 0;
	logic        present = 0;
	logic [31:0] pos_x = 0;
	logic [31:0] pos_y = 0;
	logic [31:0] pos_z = 0;
	logic [15:0] strand_id = 0;
	logic        has_pair = 0;
	logic [5:0]  pair_index = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [5:0]  neighbor_index;
	logic        found;
	logic        last;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 0;
	logic [30:0] cfg_data = 0;

	neighbor_board board;
	int  idle_count;
	bit  hold_rx;
	bit  sent_all;

	cutoff_neighbor_search_unit dut (.*);

	always #5 clk = ~clk;

	// result side: random stall per item, plus one long hold-off
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			while (hold_rx) @(negedge clk);
			w = $urandom_range(0, 17);
			if ($urandom_range(0, 3) == 0) w = 0;
			repeat (w) @(negedge clk);
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
			board.check_result(neighbor_index, found, last);
			@(negedge clk);
			out_ready <= 0;
		end
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_count <= 0;
		else idle_count <= idle_count + 1;
		if (idle_count > 20000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// valid stays up across back to back items and drops only for a gap
	task automatic send_item(bit [1:0] act, bit [5:0] idx, bit pres, bit [31:0] px,
			bit [31:0] py, bit [31:0] pz, bit [15:0] sid, bit hp, bit [5:0] pi, bit gap);
		int w;
		w = gap ? $urandom_range(0, 17) : 0;
		if (w != 0) begin
			in_valid <= 0;
			repeat (w) @(negedge clk);
		end
		in_valid <= 1;
		action <= act;
		index <= idx;
		present <= pres;
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		strand_id <= sid;
		has_pair <= hp;
		pair_index <= pi;
		do @(posedge clk); while (!in_ready);
		board.note_item(act, idx, pres, px, py, pz, sid, hp, pi);
		@(negedge clk);
	endtask

	task automatic wait_drain();
		in_valid <= 0;
		while (board.hits_q.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic write_reg(bit [1:0] idx, bit [30:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	// clustered random coordinate so cutoffs are hit often
	function automatic bit [31:0] rnd_coord(int spread);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return $urandom;
		if (r == 1) return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
		return 32'($signed($urandom_range(0, 2 * spread)) - spread);
	endfunction

	task automatic random_phase(int count, int spread);
		bit [1:0] act;
		for (int k = 0; k < count; k++) begin
			act = ($urandom_range(0, 9) < 5) ? ACT_WRITE : ACT_QUERY;
			if ($urandom_range(0, 40) == 0) act = ACT_CLEAR;
			if ($urandom_range(0, 40) == 0) act = ACT_IGNORE;
			send_item(act, $urandom_range(0, 15) == 0 ? 6'($urandom) : 6'($urandom_range(0, 11)),
				$urandom_range(0, 7) != 0, rnd_coord(spread), rnd_coord(spread),
				rnd_coord(spread), $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2)),
				1'($urandom_range(0, 1)), $urandom_range(0, 1) ? 6'($urandom) : 6'($urandom_range(0, 11)),
				$urandom_range(0, 4) != 0);
		end
	endtask

	initial begin
		board = new();
		hold_rx = 0;
		idle_count = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed: reset settings, extremes, pair and strand filters
		send_item(ACT_QUERY, 6'd0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(ACT_WRITE, 6'd0, 1, 0, 0, 0, 16'd1, 0, 0, 0);
		send_item(ACT_WRITE, 6'd1, 1, 32'd500, 0, 0, 16'd2, 1, 6'd0, 0);
		send_item(ACT_WRITE, 6'd2, 1, 0, 32'd300, 0, 16'd1, 0, 0, 0);
		send_item(ACT_WRITE, 6'd63, 1, 0, 0, 32'd999, 16'hffff, 1, 6'd63, 0);
		send_item(ACT_WRITE, 6'd3, 1, 32'h7fff_ffff, 32'h8000_0000, 0, 16'd3, 0, 0, 0);
		send_item(ACT_WRITE, 6'd4, 0, 32'd10, 32'd10, 32'd10, 16'd9, 0, 0, 0);
		send_item(ACT_WRITE, 6'd5, 1, 32'd1000, 0, 0, 16'd4, 0, 0, 0);
		send_item(ACT_QUERY, 6'd0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(ACT_QUERY, 6'd3, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(ACT_QUERY, 6'd4, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(ACT_IGNORE, 6'd0, 1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			16'hffff, 1, 6'h3f, 0);
		wait_drain();
		write_reg(REG_ALLOW_SAME, 31'd1);
		write_reg(REG_INCL_PAIRS, 31'd1);
		write_reg(REG_MIN_CUT, 31'd300);
		write_reg(REG_MAX_CUT, 31'h7fff_ffff);
		send_item(ACT_QUERY, 6'd0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(ACT_QUERY, 6'd63, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(ACT_QUERY, 6'd3, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(ACT_CLEAR, 6'd0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(ACT_QUERY, 6'd1, 0, 0, 0, 0, 0, 0, 0, 0);
		wait_drain();

		// random phases over several settings; long receiver hold-off in the first
		write_reg(REG_MIN_CUT, 31'd0);
		write_reg(REG_MAX_CUT, 31'd2000);
		fork
			begin
				hold_rx = 1;
				repeat (1500) @(negedge clk);
				hold_rx = 0;
			end
			random_phase(60, 1500);
		join
		wait_drain();
		write_reg(REG_ALLOW_SAME, 31'd0);
		write_reg(REG_INCL_PAIRS, 31'd0);
		random_phase(50, 1500);
		wait_drain();
		write_reg(REG_MIN_CUT, 31'd1000);
		write_reg(REG_MAX_CUT, 31'd500);
		random_phase(20, 1500);
		wait_drain();
		write_reg(REG_ALLOW_SAME, 31'd1);
		write_reg(REG_MIN_CUT, 31'd0);
		write_reg(REG_MAX_CUT, 31'h7fff_ffff);
		random_phase(50, 100000);
		wait_drain();
		write_reg(REG_INCL_PAIRS, 31'd1);
		write_reg(REG_MIN_CUT, 31'd400);
		write_reg(REG_MAX_CUT, 31'd1800);
		random_phase(40, 1500);
		wait_drain();

		if (board.errors == 0 && board.hits_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
